[rtl/core/cba_pkg.sv]
// Package for the checked byte accumulator ALU.
// Holds the action, error, compare and state codes and the fixed field widths.
// No dependencies; every other file of the block but cba_if imports it.
package cba_pkg;

    localparam int ACC_W   = 8;
    localparam int SLOT_W  = 4;
    localparam int MAG_W   = 8;
    localparam int PROD_W  = 16;
    localparam int STEPS   = 8;
    localparam int CNT_W   = 4;

    localparam int ACC_MAX      = 127;
    localparam int ACC_MIN      = -127;
    localparam int PRINT_LO     = 32;
    localparam int PRINT_HI     = 126;
    localparam int NEWLINE      = 10;
    localparam int SLOT_RESET   = -128;
    localparam logic [7:0] ASCII_ZERO = 8'h30;

    typedef enum logic [2:0] {
        ACT_ADD      = 3'd0,
        ACT_MUL      = 3'd1,
        ACT_DIV      = 3'd2,
        ACT_REM      = 3'd3,
        ACT_SET      = 3'd4,
        ACT_LOAD     = 3'd5,
        ACT_STORE    = 3'd6,
        ACT_CMP_EMIT = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_RANGE       = 2'd1,
        ERR_DIVZERO     = 2'd2,
        ERR_UNPRINTABLE = 2'd3
    } t_err;

    typedef enum logic [1:0] {
        CMP_LESS    = 2'd0,
        CMP_EQUAL   = 2'd1,
        CMP_GREATER = 2'd2
    } t_cmp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } t_state;

    // Result of the shared shift-and-add / shift-and-subtract unit.
    typedef struct packed {
        logic              busy;
        logic [PROD_W-1:0] prod;
        logic [MAG_W-1:0]  quot;
        logic [MAG_W-1:0]  rem;
    } t_md_status;

endpackage

[rtl/core/cba_if.sv]
// Valid/ready channel interfaces for the checked byte accumulator ALU.
// One interface for the action channel and one for the result channel.
// Depends on nothing; the field widths follow the block's fixed formats.
interface cba_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        action;
    logic signed [7:0] operand;
    logic [3:0]        slot;
    logic              emit_not_compare;

    modport source (output valid, action, operand, slot, emit_not_compare, input ready);
    modport sink (input valid, action, operand, slot, emit_not_compare, output ready);
endinterface

interface cba_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] acc_value;
    logic [1:0]        compare_code;
    logic [7:0]        char_out;
    logic              char_valid;
    logic [1:0]        error_code;

    modport source (output valid, acc_value, compare_code, char_out, char_valid, error_code,
                    input ready);
    modport sink (input valid, acc_value, compare_code, char_out, char_valid, error_code,
                  output ready);
endinterface

[rtl/core/cba_serial_md.sv]
// Bit-serial multiply and divide unit on 8-bit magnitudes.
// One multiplier bit or one quotient bit is handled per cycle.
// Depends on cba_pkg.
module cba_serial_md import cba_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_div,
    input  logic [MAG_W-1:0] i_a,
    input  logic [MAG_W-1:0] i_b,
    output t_md_status       o_status
);

    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic              r_div;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] r_mcand;
    logic [MAG_W-1:0]  r_mplier;
    logic [MAG_W-1:0]  r_quot;
    logic [MAG_W-1:0]  r_rem;
    logic [MAG_W-1:0]  r_dvsr;
    logic [MAG_W:0]    rem_sh;
    logic              fits;

    assign rem_sh = {r_rem, r_quot[MAG_W-1]};
    assign fits   = rem_sh >= {1'b0, r_dvsr};

    always_comb begin
        n_cnt = r_cnt;
        if (i_start) begin
            n_cnt = CNT_W'(STEPS);
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div    <= i_div;
            r_prod   <= '0;
            r_mcand  <= {{(PROD_W-MAG_W){1'b0}}, i_a};
            r_mplier <= i_b;
            r_quot   <= i_a;
            r_rem    <= '0;
            r_dvsr   <= i_b;
        end else if (r_cnt != '0) begin
            if (r_div) begin
                r_quot <= {r_quot[MAG_W-2:0], fits};
                if (fits) begin
                    r_rem <= MAG_W'(rem_sh - {1'b0, r_dvsr});
                end else begin
                    r_rem <= rem_sh[MAG_W-1:0];
                end
            end else begin
                if (r_mplier[0]) begin
                    r_prod <= r_prod + r_mcand;
                end
                r_mcand  <= {r_mcand[PROD_W-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[MAG_W-1:1]};
            end
        end
    end

    assign o_status.busy = r_cnt != '0;
    assign o_status.prod = r_prod;
    assign o_status.quot = r_quot;
    assign o_status.rem  = r_rem;

endmodule

[rtl/core/cba_slot_store.sv]
// Variable slot store of the checked byte accumulator ALU.
// Slots reset to -128; one write port and one registered read port.
// Depends on cba_pkg.
module cba_slot_store import cba_pkg::*; #(
    parameter int NUM_SLOTS = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_wr_en,
    input  logic [SLOT_W-1:0]       i_wr_idx,
    input  logic signed [ACC_W-1:0] i_wr_data,
    input  logic                    i_rd_en,
    input  logic [SLOT_W-1:0]       i_rd_idx,
    output logic signed [ACC_W-1:0] o_rd_data
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic signed [ACC_W-1:0] r_mem [NUM_SLOTS];
    logic signed [ACC_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_mem[k] <= ACC_W'(SLOT_RESET);
            end
        end else if (i_wr_en && ({1'b0, i_wr_idx} < (SLOT_W+1)'(NUM_SLOTS))) begin
            r_mem[i_wr_idx[IDX_W-1:0]] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en && ({1'b0, i_rd_idx} < (SLOT_W+1)'(NUM_SLOTS))) begin
            r_rd_data <= r_mem[i_rd_idx[IDX_W-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/checked_byte_accumulator_alu.sv]
// Checked byte accumulator ALU: top level of an accumulator machine for an interpreter.
// Instantiates cba_serial_md and cba_slot_store; depends on cba_pkg and cba_if.
//
// Usage:
// Actions enter on i_in (valid/ready); one result per action leaves on o_out.
// A transfer on i_in happens when valid and ready are both high, likewise on o_out.
// The block works on one action at a time. Multiply, divide and remainder pass
// through the bit-serial unit, one bit per cycle, before the result register is
// written; all other actions go to the result register without it. The block
// takes the next action only in the idle state it returns to after each result,
// so it cannot take a new action before it is through with the last one.
// The result register parts the two sides: a new action is taken while a result
// still waits. If the receiver stalls, the following result is held internally
// and i_in.ready stays low until the result register frees up.
// Accumulator and slot updates take effect when the result is written.
// Synchronous reset clears the accumulator to 0, sets every slot to -128 and
// drops o_out.valid.
module checked_byte_accumulator_alu import cba_pkg::*; #(
    parameter int NUM_SLOTS = 10
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cba_in_if.sink    i_in,
    cba_out_if.source o_out
);

    t_state                  r_state;
    t_state                  n_state;
    logic [2:0]              r_action;
    logic signed [ACC_W-1:0] r_operand;
    logic [SLOT_W-1:0]       r_slot;
    logic                    r_emit;
    logic signed [ACC_W-1:0] r_acc;

    logic                    r_out_valid;
    logic signed [ACC_W-1:0] r_out_acc;
    logic [1:0]              r_out_cmp;
    logic [7:0]              r_out_char;
    logic                    r_out_char_valid;
    logic [1:0]              r_out_err;

    logic                    accept;
    logic                    can_load;
    logic                    finish;
    logic                    commit;
    logic                    md_start;
    logic [MAG_W-1:0]        acc_mag;
    logic [MAG_W-1:0]        opnd_mag;
    t_md_status              md;
    logic signed [ACC_W-1:0] slot_data;
    logic                    slot_ok;
    logic                    neg;

    logic signed [ACC_W:0]   sum;
    logic signed [ACC_W:0]   quot_s;
    logic signed [ACC_W-1:0] res_acc;
    t_cmp                    res_cmp;
    logic [7:0]              res_char;
    logic                    res_char_valid;
    t_err                    res_err;
    logic                    store_en;

    assign accept   = i_in.valid && i_in.ready;
    assign can_load = !r_out_valid || o_out.ready;
    assign finish   = ((r_state == S_RUN) && !md.busy) || (r_state == S_HOLD);
    assign commit   = finish && can_load;
    assign md_start = accept && ((i_in.action == ACT_MUL) || (i_in.action == ACT_DIV)
                                 || (i_in.action == ACT_REM));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        i_in.ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                i_in.ready = i_rst_n;
                if (i_in.valid) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (!md.busy) begin
                    n_state = can_load ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD: begin
                if (can_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action  <= i_in.action;
            r_operand <= i_in.operand;
            r_slot    <= i_in.slot;
            r_emit    <= i_in.emit_not_compare;
        end
    end

    assign acc_mag  = r_acc[ACC_W-1] ? MAG_W'(-r_acc) : MAG_W'(r_acc);
    assign opnd_mag = i_in.operand[ACC_W-1] ? MAG_W'(-i_in.operand) : MAG_W'(i_in.operand);

    cba_serial_md u_md (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (md_start),
        .i_div    (i_in.action != ACT_MUL),
        .i_a      (acc_mag),
        .i_b      (opnd_mag),
        .o_status (md)
    );

    cba_slot_store #(.NUM_SLOTS(NUM_SLOTS)) u_slots (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (store_en),
        .i_wr_idx  (r_slot),
        .i_wr_data (r_acc),
        .i_rd_en   (accept),
        .i_rd_idx  (i_in.slot),
        .o_rd_data (slot_data)
    );

    assign slot_ok  = {1'b0, r_slot} < (SLOT_W+1)'(NUM_SLOTS);
    assign neg      = r_acc[ACC_W-1] ^ r_operand[ACC_W-1];
    assign sum      = {r_acc[ACC_W-1], r_acc} + {r_operand[ACC_W-1], r_operand};
    assign store_en = commit && (r_action == ACT_STORE) && slot_ok;

    always_comb begin
        quot_s = neg ? -$signed({1'b0, md.quot}) : $signed({1'b0, md.quot});
        if (neg && (md.rem != '0)) begin
            quot_s = quot_s - 1'b1;
        end
    end

    always_comb begin
        res_acc        = r_acc;
        res_cmp        = CMP_LESS;
        res_char       = '0;
        res_char_valid = 1'b0;
        res_err        = ERR_NONE;
        unique case (t_action'(r_action))
            ACT_ADD: begin
                if ((sum >= ACC_MIN) && (sum <= ACC_MAX)) begin
                    res_acc = sum[ACC_W-1:0];
                end else begin
                    res_err = ERR_RANGE;
                end
            end
            ACT_MUL: begin
                if (md.prod <= PROD_W'(ACC_MAX)) begin
                    res_acc = neg ? -$signed(md.prod[ACC_W-1:0]) : $signed(md.prod[ACC_W-1:0]);
                end else begin
                    res_err = ERR_RANGE;
                end
            end
            ACT_DIV: begin
                if (r_operand == '0) begin
                    res_err = ERR_DIVZERO;
                end else if (quot_s > ACC_MAX) begin
                    res_err = ERR_RANGE;
                end else begin
                    res_acc = quot_s[ACC_W-1:0];
                end
            end
            ACT_REM: begin
                if (r_operand == '0) begin
                    res_err = ERR_DIVZERO;
                end else begin
                    res_acc = r_acc[ACC_W-1] ? -$signed(md.rem) : $signed(md.rem);
                end
            end
            ACT_SET: begin
                res_acc = r_operand;
            end
            ACT_LOAD: begin
                if (slot_ok) begin
                    res_acc = slot_data;
                end else begin
                    res_err = ERR_RANGE;
                end
            end
            ACT_STORE: begin
                if (!slot_ok) begin
                    res_err = ERR_RANGE;
                end
            end
            ACT_CMP_EMIT: begin
                if (r_emit) begin
                    if ((r_acc >= 0) && (r_acc < NEWLINE)) begin
                        res_char       = ASCII_ZERO + 8'(r_acc);
                        res_char_valid = 1'b1;
                    end else if ((r_acc == NEWLINE)
                                 || ((r_acc >= PRINT_LO) && (r_acc <= PRINT_HI))) begin
                        res_char       = 8'(r_acc);
                        res_char_valid = 1'b1;
                    end else begin
                        res_err = ERR_UNPRINTABLE;
                    end
                end else if (slot_ok) begin
                    if (r_acc < slot_data) begin
                        res_cmp = CMP_LESS;
                    end else if (r_acc == slot_data) begin
                        res_cmp = CMP_EQUAL;
                    end else begin
                        res_cmp = CMP_GREATER;
                    end
                end else begin
                    res_err = ERR_RANGE;
                end
            end
            default: res_err = ERR_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (commit) begin
            r_acc <= res_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_acc        <= res_acc;
            r_out_cmp        <= res_cmp;
            r_out_char       <= res_char;
            r_out_char_valid <= res_char_valid;
            r_out_err        <= res_err;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.acc_value    = r_out_acc;
    assign o_out.compare_code = r_out_cmp;
    assign o_out.char_out     = r_out_char;
    assign o_out.char_valid   = r_out_char_valid;
    assign o_out.error_code   = r_out_err;

endmodule

[dv/cba_checker.sv]
`timescale 1ns / 100ps
// Result checker for the checked byte accumulator ALU testbench.
// Watches the action and result channels, predicts each result and compares it.
// Depends on cba_pkg and the channel interfaces in cba_if.
module cba_checker import cba_pkg::*; #(
    parameter int NUM_SLOTS = 10
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cba_in_if    i_act,
    cba_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic signed [ACC_W-1:0] acc;
        t_cmp                    cmp;
        logic [7:0]              ch;
        logic                    ch_v;
        t_err                    err;
    } t_result;

    logic signed [ACC_W-1:0] acc_q;
    logic signed [ACC_W-1:0] var_q [NUM_SLOTS];
    t_result                 awaited_results [$];

    task automatic run_action(input t_action act, input logic signed [7:0] opnd,
                              input logic [3:0] idx, input logic emit, output t_result r);
        int   a;
        int   b;
        int   t;
        logic in_range;
        a        = int'(acc_q);
        b        = int'(opnd);
        in_range = idx < NUM_SLOTS;
        r.cmp    = CMP_LESS;
        r.ch     = 8'h00;
        r.ch_v   = 1'b0;
        r.err    = ERR_NONE;
        case (act)
            ACT_ADD, ACT_MUL: begin
                t = (act == ACT_ADD) ? a + b : a * b;
                if (t >= ACC_MIN && t <= ACC_MAX) acc_q = t[7:0];
                else r.err = ERR_RANGE;
            end
            ACT_DIV: begin
                if (b == 0) begin
                    r.err = ERR_DIVZERO;
                end else begin
                    t = a / b;
                    if (a % b != 0 && ((a < 0) != (b < 0))) t = t - 1;
                    if (t > ACC_MAX) r.err = ERR_RANGE;
                    else acc_q = t[7:0];
                end
            end
            ACT_REM: begin
                if (b == 0) begin
                    r.err = ERR_DIVZERO;
                end else begin
                    t     = a % b;
                    acc_q = t[7:0];
                end
            end
            ACT_SET: acc_q = opnd;
            ACT_LOAD: begin
                if (in_range) acc_q = var_q[idx];
                else r.err = ERR_RANGE;
            end
            ACT_STORE: begin
                if (in_range) var_q[idx] = acc_q;
                else r.err = ERR_RANGE;
            end
            ACT_CMP_EMIT: begin
                if (emit) begin
                    if (a >= 0 && a < NEWLINE) begin
                        r.ch   = ASCII_ZERO + 8'(a);
                        r.ch_v = 1'b1;
                    end else if (a == NEWLINE || (a >= PRINT_LO && a <= PRINT_HI)) begin
                        r.ch   = 8'(a);
                        r.ch_v = 1'b1;
                    end else begin
                        r.err = ERR_UNPRINTABLE;
                    end
                end else if (in_range) begin
                    t     = int'(var_q[idx]);
                    r.cmp = (a < t) ? CMP_LESS : (a == t) ? CMP_EQUAL : CMP_GREATER;
                end else begin
                    r.err = ERR_RANGE;
                end
            end
        endcase
        r.acc = acc_q;
    endtask

    task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            acc_q = '0;
            foreach (var_q[k]) var_q[k] = ACC_W'(SLOT_RESET);
            awaited_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_res.valid === 1'b1 && i_res.ready === 1'b1) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result transfer, expected none, actual acc %0d",
                             $time, i_res.acc_value);
                    o_fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("acc_value", want.acc, i_res.acc_value);
                    check_field("compare_code", 8'(want.cmp), 8'(i_res.compare_code));
                    check_field("char_out", want.ch, i_res.char_out);
                    check_field("char_valid", 8'(want.ch_v), 8'(i_res.char_valid));
                    check_field("error_code", 8'(want.err), 8'(i_res.error_code));
                end
            end
            if (i_act.valid === 1'b1 && i_act.ready === 1'b1) begin
                run_action(t_action'(i_act.action), i_act.operand, i_act.slot,
                           i_act.emit_not_compare, want);
                awaited_results.push_back(want);
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// Top of the checked byte accumulator ALU testbench: clock, reset and stimulus.
// Instantiates the block and cba_checker; depends on cba_pkg and cba_if.
module tb;
    import cba_pkg::*;

    localparam logic COMPARE  = 1'b0;
    localparam logic EMIT     = 1'b1;
    localparam int   N_RANDOM = 950;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;
    bit   quiet;

    cba_in_if  in_ch ();
    cba_out_if out_ch ();

    checked_byte_accumulator_alu u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    cba_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_act        (in_ch),
        .i_res        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 clk = ~clk;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send(input t_action act, input logic signed [7:0] opnd,
                        input logic [3:0] idx, input logic emit);
        int gap;
        gap = quiet ? 0 : idle_len();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.action           <= act;
        in_ch.operand          <= opnd;
        in_ch.slot             <= idx;
        in_ch.emit_not_compare <= emit;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    task automatic send_random();
        logic signed [7:0] opnd;
        logic [3:0]        idx;
        int                pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            opnd = 8'($urandom_range(0, 24) - 12);
        end else if (pick == 6) begin
            case ($urandom_range(0, 4))
                0: opnd = 8'sd0;
                1: opnd = 8'sd1;
                2: opnd = -8'sd1;
                3: opnd = 8'sd127;
                default: opnd = -8'sd128;
            endcase
        end else begin
            opnd = 8'($urandom);
        end
        if ($urandom_range(0, 99) < 85) idx = 4'($urandom_range(0, 9));
        else idx = 4'($urandom_range(10, 15));
        send(t_action'($urandom_range(0, 7)), opnd, idx, 1'($urandom_range(0, 1)));
    endtask

    // Receiver: long stalls, stretches of steady acceptance, and random single-cycle stalls.
    initial begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            case ($urandom_range(0, 9))
                0: begin
                    out_ch.ready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(posedge clk);
                end
                1, 2: begin
                    out_ch.ready <= 1'b1;
                    repeat ($urandom_range(30, 120)) @(posedge clk);
                end
                default: begin
                    out_ch.ready <= ($urandom_range(0, 2) != 0);
                    @(posedge clk);
                end
            endcase
        end
    end

    initial begin
        rst_n                  <= 1'b0;
        in_ch.valid            <= 1'b0;
        in_ch.action           <= ACT_ADD;
        in_ch.operand          <= '0;
        in_ch.slot             <= '0;
        in_ch.emit_not_compare <= COMPARE;
        quiet = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(ACT_CMP_EMIT, 0, 0, COMPARE);
        send(ACT_CMP_EMIT, 0, 0, EMIT);
        send(ACT_LOAD, 0, 9, COMPARE);
        send(ACT_CMP_EMIT, 0, 9, EMIT);
        send(ACT_DIV, -1, 0, COMPARE);
        send(ACT_DIV, 0, 0, COMPARE);
        send(ACT_REM, 0, 0, COMPARE);
        send(ACT_DIV, 2, 0, COMPARE);
        send(ACT_REM, -1, 0, COMPARE);
        send(ACT_SET, 127, 0, COMPARE);
        send(ACT_ADD, 1, 0, COMPARE);
        send(ACT_MUL, -1, 0, COMPARE);
        send(ACT_ADD, -1, 0, COMPARE);
        send(ACT_MUL, 127, 0, COMPARE);
        send(ACT_SET, -7, 0, COMPARE);
        send(ACT_DIV, 2, 0, COMPARE);
        send(ACT_SET, -7, 0, COMPARE);
        send(ACT_REM, 2, 0, COMPARE);
        send(ACT_STORE, 0, 15, COMPARE);
        send(ACT_LOAD, 0, 10, COMPARE);
        send(ACT_CMP_EMIT, 0, 12, COMPARE);
        send(ACT_STORE, 0, 3, COMPARE);
        send(ACT_CMP_EMIT, 0, 3, COMPARE);
        send(ACT_SET, 10, 0, EMIT);
        send(ACT_CMP_EMIT, 0, 3, EMIT);
        send(ACT_SET, 31, 0, COMPARE);
        send(ACT_CMP_EMIT, 0, 0, EMIT);
        send(ACT_SET, 126, 0, COMPARE);
        send(ACT_CMP_EMIT, 0, 0, EMIT);
        drain();

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
            if (n == N_RANDOM / 2) drain();
            send_random();
        end

        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("PASS checked_byte_accumulator_alu");
        end else begin
            $display("FAIL checked_byte_accumulator_alu");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAIL checked_byte_accumulator_alu");
        $finish;
    end

endmodule
